[rtl/spmq_pkg.sv]
// Shared types, codes and helpers for the shared-pool typed message queue.
// No dependencies; every other file imports this package.
`default_nettype none

package spmq_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int NUM_TYPES_DEF = 16;
  localparam int MSG_BYTES_DEF = 8;

  localparam int DATA_W     = 64;
  localparam int LEN_W      = 4;
  localparam int MTYPE_W    = 8;
  localparam int CMDQ_DEPTH = 2;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_TYPE  = 3'd1,
    ST_TOO_SHORT = 3'd2,
    ST_POOL_FULL = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef struct packed {
    req_t                req_type;
    logic [MTYPE_W-1:0]  msg_type;
    logic [LEN_W-1:0]    length;
    logic [DATA_W-1:0]   payload_data;
  } in_t;

  typedef struct packed {
    status_t             status;
    logic [LEN_W-1:0]    byte_count;
    logic [DATA_W-1:0]   read_data;
  } out_t;

  typedef struct packed {
    logic                done;
    req_t                req_type;
    status_t             status;
    logic [MTYPE_W-1:0]  msg_type;
    logic [LEN_W-1:0]    length;
    logic [DATA_W-1:0]   payload_data;
  } cmd_t;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_PTR,
    BE_SLOT,
    BE_DATA
  } be_state_t;

  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < DATA_W / 8; b++) begin
      m[8*b +: 8] = {8{(LEN_W'(b) < n)}};
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/spmq_front.sv]
// Front end: configuration register, request hand-off and classification.
// Depends on spmq_pkg; feeds spmq_cmdq.
`default_nettype none

module spmq_front import spmq_pkg::*; #(
  parameter int NUM_TYPES = NUM_TYPES_DEF,
  parameter int MSG_BYTES = MSG_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire in_t              in_data,
  input  wire logic             cfg_we,
  input  wire logic [LEN_W-1:0] cfg_wdata,
  input  wire logic             q_full,
  output logic                  busy,
  output logic                  q_push,
  output cmd_t                  q_wdata
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MSG_BYTES + 1);

  logic [LEN_W-1:0] min_len_r;
  logic [LEN_W-1:0] len_sat;
  logic [LEN_W-1:0] psize;
  logic             type_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= '0;
    end else if (cfg_we) begin
      min_len_r <= cfg_wdata;
    end
  end

  assign busy    = q_full;
  assign q_push  = start && !q_full;
  assign type_ok = {1'b0, in_data.msg_type} < (MTYPE_W + 1)'(NUM_TYPES);
  assign len_sat = (in_data.length > MAX_LEN) ? MAX_LEN : in_data.length;
  assign psize   = len_sat - 1'b1;

  always_comb begin
    q_wdata              = '0;
    q_wdata.req_type     = in_data.req_type;
    q_wdata.msg_type     = in_data.msg_type;
    q_wdata.length       = in_data.length;
    q_wdata.payload_data = in_data.payload_data;
    q_wdata.status       = ST_OK;
    if (in_data.req_type == REQ_PUSH) begin
      priority if (in_data.length == '0) begin
        q_wdata.done = 1'b1;
      end else if (!type_ok) begin
        q_wdata.done   = 1'b1;
        q_wdata.status = ST_BAD_TYPE;
      end else if (psize < min_len_r) begin
        q_wdata.done   = 1'b1;
        q_wdata.status = ST_TOO_SHORT;
      end else begin
        q_wdata.length = len_sat;
      end
    end else if (!type_ok) begin
      q_wdata.done   = 1'b1;
      q_wdata.status = ST_BAD_TYPE;
    end
  end

endmodule

`default_nettype wire

[rtl/spmq_cmdq.sv]
// Short command queue between front end and back end.
// Depends on spmq_pkg.
`default_nettype none

module spmq_cmdq import spmq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t wdata,
  input  wire logic pop,
  output cmd_t      head,
  output logic      full,
  output logic      empty
);

  localparam int AW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t            entry_r [CMDQ_DEPTH];
  logic [AW-1:0]   wptr_r;
  logic [AW-1:0]   rptr_r;
  logic [CW-1:0]   cnt_r;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head  = entry_r[rptr_r];
  assign full  = (cnt_r == CW'(CMDQ_DEPTH));
  assign empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= ptr_inc(wptr_r);
      end
      if (pop) begin
        rptr_r <= ptr_inc(rptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/spmq_back.sv]
// Back end: slot pool, per-type slot FIFOs, pointer store and result register.
// Depends on spmq_pkg; takes commands from spmq_cmdq.
`default_nettype none

module spmq_back import spmq_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int NUM_TYPES = NUM_TYPES_DEF,
  parameter int MSG_BYTES = MSG_BYTES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  wire cmd_t q_head,
  output logic      q_pop,
  output logic      out_valid,
  output out_t      out_data
);

  localparam int SLOT_W       = $clog2(NUM_SLOTS);
  localparam int FIFO_DEPTH   = NUM_SLOTS + 1;
  localparam int PTR_W        = $clog2(FIFO_DEPTH);
  localparam int TYPE_W       = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int FIFO_ENTRIES = NUM_TYPES * FIFO_DEPTH;
  localparam int FADDR_W      = $clog2(FIFO_ENTRIES);
  localparam int PAY_W        = MSG_BYTES * 8;

  typedef struct packed {
    logic [PTR_W-1:0] rd;
    logic [PTR_W-1:0] wr;
  } ptr_pair_t;

  typedef struct packed {
    logic [LEN_W-1:0] size;
    logic [PAY_W-1:0] data;
  } slot_ent_t;

  ptr_pair_t           ptr_mem  [NUM_TYPES];
  logic [SLOT_W-1:0]   fifo_mem [FIFO_ENTRIES];
  slot_ent_t           slot_mem [NUM_SLOTS];

  logic [NUM_TYPES-1:0] ptr_vld_r;
  ptr_pair_t            ptr_q_r;
  logic                 ptr_q_vld_r;
  logic [SLOT_W-1:0]    fifo_q_r;
  slot_ent_t            slot_q_r;
  logic [NUM_SLOTS-1:0] busy_r;
  logic [SLOT_W-1:0]    hint_r;
  be_state_t            state_r;
  be_state_t            state_nxt;
  cmd_t                 cur_r;
  logic                 out_valid_r;
  out_t                 out_data_r;

  logic [TYPE_W-1:0]    head_ty;
  logic [TYPE_W-1:0]    cur_ty;
  logic [PTR_W-1:0]     cur_rd;
  logic [PTR_W-1:0]     cur_wr;
  logic [PTR_W-1:0]     rd_inc;
  logic [PTR_W-1:0]     wr_inc;
  logic                 ptr_empty;
  logic [FADDR_W-1:0]   fifo_addr;
  logic [LEN_W-1:0]     psize;
  logic [DATA_W-1:0]    push_masked;
  slot_ent_t            slot_wdata;
  logic [LEN_W-1:0]     pop_count;
  logic [DATA_W-1:0]    pop_data;
  logic                 slot_found;
  logic [SLOT_W-1:0]    free_slot;
  logic [SLOT_W-1:0]    hint_nxt;
  ptr_pair_t            ptr_wdata;

  logic                 ptr_we;
  logic                 fifo_we;
  logic                 fifo_re;
  logic                 slot_we;
  logic                 slot_re;
  logic                 busy_set;
  logic                 busy_clr;
  logic                 res_vld;
  out_t                 res;

  assign head_ty   = q_head.msg_type[TYPE_W-1:0];
  assign cur_ty    = cur_r.msg_type[TYPE_W-1:0];
  assign cur_rd    = ptr_q_vld_r ? ptr_q_r.rd : '0;
  assign cur_wr    = ptr_q_vld_r ? ptr_q_r.wr : '0;
  assign rd_inc    = (cur_rd == PTR_W'(NUM_SLOTS)) ? '0 : cur_rd + 1'b1;
  assign wr_inc    = (cur_wr == PTR_W'(NUM_SLOTS)) ? '0 : cur_wr + 1'b1;
  assign ptr_empty = (cur_rd == cur_wr);
  assign fifo_addr = FADDR_W'(cur_ty) * FADDR_W'(FIFO_DEPTH)
                   + FADDR_W'((cur_r.req_type == REQ_POP) ? cur_rd : cur_wr);

  assign psize           = cur_r.length - 1'b1;
  assign push_masked     = cur_r.payload_data & byte_mask(psize);
  assign slot_wdata.size = psize;
  assign slot_wdata.data = push_masked[PAY_W-1:0];

  assign pop_count = (cur_r.length < slot_q_r.size) ? cur_r.length : slot_q_r.size;
  assign pop_data  = DATA_W'(slot_q_r.data) & byte_mask(pop_count);

  assign hint_nxt  = (free_slot == SLOT_W'(NUM_SLOTS - 1)) ? '0 : free_slot + 1'b1;

  // rotating first-free search starting at the hint
  always_comb begin
    logic              hi_found;
    logic              lo_found;
    logic [SLOT_W-1:0] hi_idx;
    logic [SLOT_W-1:0] lo_idx;
    hi_found = 1'b0;
    lo_found = 1'b0;
    hi_idx   = '0;
    lo_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        lo_found = 1'b1;
        lo_idx   = SLOT_W'(i);
        if (SLOT_W'(i) >= hint_r) begin
          hi_found = 1'b1;
          hi_idx   = SLOT_W'(i);
        end
      end
    end
    slot_found = lo_found;
    free_slot  = hi_found ? hi_idx : lo_idx;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BE_IDLE: begin
        if (!q_empty && !q_head.done) begin
          state_nxt = BE_PTR;
        end
      end
      BE_PTR: begin
        if (cur_r.req_type == REQ_POP && !ptr_empty) begin
          state_nxt = BE_SLOT;
        end else begin
          state_nxt = BE_IDLE;
        end
      end
      BE_SLOT: state_nxt = BE_DATA;
      BE_DATA: state_nxt = BE_IDLE;
      default: state_nxt = BE_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    ptr_we    = 1'b0;
    fifo_we   = 1'b0;
    fifo_re   = 1'b0;
    slot_we   = 1'b0;
    slot_re   = 1'b0;
    busy_set  = 1'b0;
    busy_clr  = 1'b0;
    res_vld   = 1'b0;
    res       = '0;
    ptr_wdata = '0;
    unique case (state_r)
      BE_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.done) begin
            res_vld    = 1'b1;
            res.status = q_head.status;
          end
        end
      end
      BE_PTR: begin
        if (cur_r.req_type == REQ_PUSH) begin
          res_vld = 1'b1;
          if (!slot_found) begin
            res.status = ST_POOL_FULL;
          end else begin
            ptr_we         = 1'b1;
            ptr_wdata.rd   = cur_rd;
            ptr_wdata.wr   = wr_inc;
            fifo_we        = 1'b1;
            slot_we        = 1'b1;
            busy_set       = 1'b1;
            res.status     = ST_OK;
            res.byte_count = cur_r.length;
          end
        end else if (ptr_empty) begin
          res_vld    = 1'b1;
          res.status = ST_EMPTY;
        end else begin
          fifo_re      = 1'b1;
          ptr_we       = 1'b1;
          ptr_wdata.rd = rd_inc;
          ptr_wdata.wr = cur_wr;
        end
      end
      BE_SLOT: begin
        slot_re  = 1'b1;
        busy_clr = 1'b1;
      end
      BE_DATA: begin
        res_vld        = 1'b1;
        res.status     = ST_OK;
        res.byte_count = pop_count;
        res.read_data  = pop_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ptr_q_r <= ptr_mem[head_ty];
      cur_r   <= q_head;
    end
    if (ptr_we) begin
      ptr_mem[cur_ty] <= ptr_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[fifo_addr] <= free_slot;
    end
    if (fifo_re) begin
      fifo_q_r <= fifo_mem[fifo_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[free_slot] <= slot_wdata;
    end
    if (slot_re) begin
      slot_q_r <= slot_mem[fifo_q_r];
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BE_IDLE;
      ptr_vld_r   <= '0;
      ptr_q_vld_r <= 1'b0;
      busy_r      <= '0;
      hint_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= res_vld;
      if (q_pop) begin
        ptr_q_vld_r <= ptr_vld_r[head_ty];
      end
      if (ptr_we) begin
        ptr_vld_r[cur_ty] <= 1'b1;
      end
      if (busy_set) begin
        busy_r[free_slot] <= 1'b1;
        hint_r            <= hint_nxt;
      end
      if (busy_clr) begin
        busy_r[fifo_q_r] <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/shared_pool_typed_message_queue.sv]
// Top level of the shared-pool typed message queue: front end, command queue, back end.
// Depends on spmq_pkg, spmq_front, spmq_cmdq and spmq_back.
//
//   channel  ports                          transfer when
//   -------  -----------------------------  ---------------------
//   request  start, busy, in_data           start && !busy
//   result   out_valid, out_data            out_valid (one cycle)
//   config   cfg_we, cfg_wdata              cfg_we
//
// Rejected requests and empty pushes finish in the back-end idle state. Push: pointer
// store read, then slot/FIFO/pointer write. Pop: pointer read, FIFO read, slot read,
// result. The back-end sequencer and its pointer store set these steps.
// Reset is synchronous; no clearing pass, requests are taken right after reset.
// busy rises only while the two-entry command queue is full; results cannot stall.
`default_nettype none

module shared_pool_typed_message_queue import spmq_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int NUM_TYPES = NUM_TYPES_DEF,
  parameter int MSG_BYTES = MSG_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_t              in_data,
  output logic                  out_valid,
  output out_t                  out_data,
  input  wire logic             cfg_we,
  input  wire logic [LEN_W-1:0] cfg_wdata
);

  logic q_push;
  cmd_t q_wdata;
  logic q_pop;
  cmd_t q_head;
  logic q_full;
  logic q_empty;

  spmq_front #(
    .NUM_TYPES (NUM_TYPES),
    .MSG_BYTES (MSG_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .busy      (busy),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  spmq_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  spmq_back #(
    .NUM_SLOTS (NUM_SLOTS),
    .NUM_TYPES (NUM_TYPES),
    .MSG_BYTES (MSG_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[rtl/spmq_checker.sv]
// Port-level checks for the shared-pool typed message queue, bound to the top level.
// Depends on spmq_pkg and shared_pool_typed_message_queue.
`default_nettype none

module spmq_checker import spmq_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire out_t out_data
);

  logic [2:0] pending_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 3'(start && !busy) - 3'(out_valid);
    end
  end

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("result or busy right after reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 3'd0)
    else $error("result without an accepted request");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.byte_count == '0 && out_data.read_data == '0)
    else $error("error result carries data");

  a_data_masked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.read_data & ~byte_mask(out_data.byte_count)) == '0)
    else $error("read data beyond byte count");

endmodule

bind shared_pool_typed_message_queue spmq_checker u_spmq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
